// File: rtl/lmc_pkg.sv
`timescale 1ns / 1ps

package lmc_pkg;

  // Kernel geometry. The weight table below belongs to the 7x7 build.
  localparam int KERNEL_SIZE = 7;
  localparam int HALF_K      = KERNEL_SIZE / 2;
  localparam int TAP_DIV     = KERNEL_SIZE * KERNEL_SIZE;

  // Default image limits for the top-level parameters.
  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int MAX_HEIGHT_DEF = 1024;

  // Field and register widths.
  localparam int PIX_W  = 8;
  localparam int POS_W  = 10;
  localparam int CFG_W  = 11;
  localparam int CFG_IDX_W = 1;

  localparam int WIDTH_RESET  = 640;
  localparam int HEIGHT_RESET = 480;

  // Integer LoG weights, sigma 1.4, scale 400, truncated.
  localparam int LOG_WEIGHTS [KERNEL_SIZE][KERNEL_SIZE] = '{
    '{  2,   5,   7,   8,   7,   5,   2 },
    '{  5,   8,   5,   0,   5,   8,   5 },
    '{  7,   5, -19, -37, -19,   5,   7 },
    '{  8,   0, -37, -64, -37,   0,   8 },
    '{  7,   5, -19, -37, -19,   5,   7 },
    '{  5,   8,   5,   0,   5,   8,   5 },
    '{  2,   5,   7,   8,   7,   5,   2 }
  };

  // Division by TAP_DIV is a multiply by a rounded-up reciprocal. The
  // largest product |w|*p is 64*255, well inside the exact range.
  localparam int AW_W      = 7;
  localparam int PROD_W    = PIX_W + AW_W;
  localparam int DIV_SHIFT = 20;
  localparam int DIV_RECIP = (2 ** DIV_SHIFT + TAP_DIV - 1) / TAP_DIV;

  // Quotient magnitude is at most 333; signed sums grow by three bits
  // for each group of seven terms.
  localparam int QW        = 10;
  localparam int TERM_W    = QW + 1;
  localparam int ROW_SUM_W = TERM_W + 3;
  localparam int TOT_W     = ROW_SUM_W + 3;
  localparam int PIX_MAX   = 255;

  typedef logic [PIX_W-1:0] pix_t;
  typedef pix_t [KERNEL_SIZE-1:0] col_t;
  typedef col_t [KERNEL_SIZE-1:0] win_t;
  typedef pix_t [KERNEL_SIZE-2:0] line_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             frame_start;
  } lmc_req_t;

  typedef struct packed {
    logic [PIX_W-1:0] filtered;
    logic [POS_W-1:0] out_row;
    logic [POS_W-1:0] out_col;
    logic             frame_end;
  } lmc_rsp_t;

  // Position of the centre pixel that travels beside the window.
  typedef struct packed {
    logic [POS_W-1:0] row;
    logic [POS_W-1:0] col;
    logic             frame_end;
  } lmc_pos_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH  = 1'b0,
    REG_IMAGE_HEIGHT = 1'b1
  } cfg_reg_t;

  // trunc(aw * p / TAP_DIV) for a non-negative weight magnitude.
  function automatic logic [QW-1:0] tap_quot(input pix_t p, input logic [AW_W-1:0] aw);
    logic [PROD_W-1:0]   x;
    logic [2*PROD_W-1:0] y;
    x = PROD_W'(p) * PROD_W'(aw);
    y = (2*PROD_W)'(x) * (2*PROD_W)'(DIV_RECIP);
    return y[DIV_SHIFT +: QW];
  endfunction

endpackage

// File: rtl/lmc_kernel.sv
`timescale 1ns / 1ps

module lmc_kernel (
  input  logic             clk,
  input  logic             rst,
  input  logic             take_valid,
  output logic             take_ready,
  input  lmc_pkg::win_t    win,
  input  lmc_pkg::lmc_pos_t tag,
  output logic             rsp_valid,
  input  logic             rsp_stall,
  output lmc_pkg::lmc_rsp_t rsp
);
  import lmc_pkg::*;

  logic signed [TERM_W-1:0]    term_next [KERNEL_SIZE][KERNEL_SIZE];
  logic signed [TERM_W-1:0]    k1_term [KERNEL_SIZE][KERNEL_SIZE];
  lmc_pos_t                    k1_tag;
  logic                        k1_v;
  logic signed [ROW_SUM_W-1:0] row_next [KERNEL_SIZE];
  logic signed [ROW_SUM_W-1:0] k2_row [KERNEL_SIZE];
  lmc_pos_t                    k2_tag;
  logic                        k2_v;
  logic signed [TOT_W-1:0]     total;
  logic [PIX_W-1:0]            clamped;
  logic                        out_ready, k2_ready, k1_ready;

  assign out_ready  = !rsp_valid || !rsp_stall;
  assign k2_ready   = !k2_v || out_ready;
  assign k1_ready   = !k1_v || k2_ready;
  assign take_ready = k1_ready;

  // One signed quotient per tap; each is a function of an 8-bit pixel.
  always_comb begin
    for (int r = 0; r < KERNEL_SIZE; r++) begin
      for (int k = 0; k < KERNEL_SIZE; k++) begin
        if (LOG_WEIGHTS[r][k] < 0) begin
          term_next[r][k] = -TERM_W'(tap_quot(win[r][k], AW_W'(-LOG_WEIGHTS[r][k])));
        end else begin
          term_next[r][k] = TERM_W'(tap_quot(win[r][k], AW_W'(LOG_WEIGHTS[r][k])));
        end
      end
    end
  end

  always_comb begin
    for (int r = 0; r < KERNEL_SIZE; r++) begin
      row_next[r] = '0;
      for (int k = 0; k < KERNEL_SIZE; k++) begin
        row_next[r] = row_next[r] + ROW_SUM_W'(k1_term[r][k]);
      end
    end
  end

  always_comb begin
    total = '0;
    for (int r = 0; r < KERNEL_SIZE; r++) begin
      total = total + TOT_W'(k2_row[r]);
    end
    if (total < 0) begin
      clamped = '0;
    end else if (total > TOT_W'(PIX_MAX)) begin
      clamped = PIX_W'(PIX_MAX);
    end else begin
      clamped = total[PIX_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      k1_v      <= 1'b0;
      k2_v      <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      if (k1_ready) begin
        k1_v <= take_valid;
      end
      if (k2_ready) begin
        k2_v <= k1_v;
      end
      if (out_ready) begin
        rsp_valid <= k2_v;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take_valid && k1_ready) begin
      k1_term <= term_next;
      k1_tag  <= tag;
    end
    if (k1_v && k2_ready) begin
      k2_row <= row_next;
      k2_tag <= k1_tag;
    end
    if (k2_v && out_ready) begin
      rsp.filtered  <= clamped;
      rsp.out_row   <= k2_tag.row;
      rsp.out_col   <= k2_tag.col;
      rsp.frame_end <= k2_tag.frame_end;
    end
  end

endmodule

// File: rtl/log_mask_convolution.sv
`timescale 1ns / 1ps

// Streaming 7x7 Laplacian-of-Gaussian filter for an 8-bit grey image.
// Requests arrive on req (pixel, frame_start) in raster order under
// req_valid/req_stall; a request is taken at a clock edge with req_valid
// high and req_stall low. frame_start moves the raster position to row 0,
// column 0. Responses leave on rsp (filtered, out_row, out_col, frame_end)
// under rsp_valid/rsp_stall, one per interior pixel; border pixels give
// none. The image size comes from two registers written through cfg_we,
// cfg_index and cfg_data; the user must write them only while the block
// is idle, which the block itself does not enforce. Throughput is one
// pixel per clock unless the reset sweep or a response stall holds it.
// The line-store read is registered on the edge that takes a request;
// the column then moves into the window, and the arithmetic pipeline
// follows (tap quotients, row sums, total and clamp into the output
// register). After reset the line store is swept to zero, one column
// per cycle, over all MAX_WIDTH columns; req_stall stays high meanwhile.
// When the receiver stalls, the output register holds its response and
// the pipeline keeps taking pixels until its stages are full; a border
// pixel leaves at the window stage, yet may wait behind an interior one.
module log_mask_convolution #(
  parameter int MAX_WIDTH  = lmc_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = lmc_pkg::MAX_HEIGHT_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         req_valid,
  output logic                         req_stall,
  input  lmc_pkg::lmc_req_t            req,
  output logic                         rsp_valid,
  input  logic                         rsp_stall,
  output lmc_pkg::lmc_rsp_t            rsp,
  input  logic                         cfg_we,
  input  logic [lmc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [lmc_pkg::CFG_W-1:0]    cfg_data
);
  import lmc_pkg::*;

  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int RW  = $clog2(MAX_HEIGHT);
  localparam int SZW = ($clog2(MAX_WIDTH + 1) > CFG_W) ? $clog2(MAX_WIDTH + 1) : CFG_W;
  localparam int SZH = ($clog2(MAX_HEIGHT + 1) > CFG_W) ? $clog2(MAX_HEIGHT + 1) : CFG_W;
  localparam int OCW = (CW > POS_W) ? CW : POS_W;
  localparam int ORW = (RW > POS_W) ? RW : POS_W;
  localparam int LW  = (KERNEL_SIZE - 1) * PIX_W;

  // Configuration registers and their clamped working values.
  logic [CFG_W-1:0] cfg_width, cfg_height;
  logic [SZW-1:0]   width_ext, img_w;
  logic [SZH-1:0]   height_ext, img_h;

  // Raster position of the next pixel.
  logic [CW-1:0] col_count, col_count_next, cur_col;
  logic [RW-1:0] row_count, row_count_next, cur_row;
  logic          accept, cur_emit;
  lmc_pos_t      cur_pos;
  logic [OCW-1:0] col_out;
  logic [ORW-1:0] row_out;

  // Line store: one word per column holds the six older rows.
  logic [LW-1:0] mem [MAX_WIDTH];
  logic [LW-1:0] mem_rdata, mem_wdata;
  logic [CW-1:0] mem_waddr;
  logic          mem_we;
  logic          clearing;
  logic [CW-1:0] clear_addr;

  // Stage 1: line-store word is available.
  logic          s1_v, s1_emit, s1_fwd, s1_ready, s1_leave;
  logic [CW-1:0] s1_col;
  pix_t          s1_px;
  lmc_pos_t      s1_pos;
  line_t         s1_fwd_data, s1_line, s1_line_next;
  col_t          s1_column;

  // Stage 2: the window register.
  logic     s2_v, s2_emit, s2_ready;
  lmc_pos_t s2_pos;
  win_t     window, window_next;
  logic     k_ready;

  always_comb begin
    width_ext  = SZW'(cfg_width);
    height_ext = SZH'(cfg_height);
    if (width_ext < SZW'(KERNEL_SIZE)) begin
      img_w = SZW'(KERNEL_SIZE);
    end else if (width_ext > SZW'(MAX_WIDTH)) begin
      img_w = SZW'(MAX_WIDTH);
    end else begin
      img_w = width_ext;
    end
    if (height_ext < SZH'(KERNEL_SIZE)) begin
      img_h = SZH'(KERNEL_SIZE);
    end else if (height_ext > SZH'(MAX_HEIGHT)) begin
      img_h = SZH'(MAX_HEIGHT);
    end else begin
      img_h = height_ext;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_width  <= CFG_W'(WIDTH_RESET);
      cfg_height <= CFG_W'(HEIGHT_RESET);
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_IMAGE_WIDTH: begin
          cfg_width <= cfg_data;
        end
        REG_IMAGE_HEIGHT: begin
          cfg_height <= cfg_data;
        end
      endcase
    end
  end

  // Handshake: each stage moves when the one after it has room. A border
  // pixel leaves the window stage without entering the arithmetic.
  assign s2_ready  = !s2_v || !s2_emit || k_ready;
  assign s1_ready  = !s1_v || s2_ready;
  assign s1_leave  = s1_v && s2_ready;
  assign req_stall = clearing || !s1_ready;
  assign accept    = req_valid && !req_stall;

  // Position of this pixel, whether it yields a response, and where the
  // raster goes next. A position left past a shrunken edge wraps here.
  always_comb begin
    cur_col = req.frame_start ? '0 : col_count;
    cur_row = req.frame_start ? '0 : row_count;
    cur_emit = (cur_row >= RW'(KERNEL_SIZE - 1)) && (cur_col >= CW'(KERNEL_SIZE - 1)) &&
               (SZH'(cur_row) < img_h) && (SZW'(cur_col) < img_w);
    col_out = OCW'(cur_col) - OCW'(HALF_K);
    row_out = ORW'(cur_row) - ORW'(HALF_K);
    cur_pos.row = row_out[POS_W-1:0];
    cur_pos.col = col_out[POS_W-1:0];
    cur_pos.frame_end = (SZH'(cur_row) == img_h - SZH'(1)) &&
                        (SZW'(cur_col) == img_w - SZW'(1));
    if (SZW'(cur_col) + SZW'(1) >= img_w) begin
      col_count_next = '0;
      if (SZH'(cur_row) + SZH'(1) >= img_h) begin
        row_count_next = '0;
      end else begin
        row_count_next = cur_row + RW'(1);
      end
    end else begin
      col_count_next = cur_col + CW'(1);
      row_count_next = cur_row;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_count <= '0;
      row_count <= '0;
    end else if (accept) begin
      col_count <= col_count_next;
      row_count <= row_count_next;
    end
  end

  // Reset sweep over the line store.
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing   <= 1'b1;
      clear_addr <= '0;
    end else if (clearing) begin
      if (clear_addr == CW'(MAX_WIDTH - 1)) begin
        clearing <= 1'b0;
      end else begin
        clear_addr <= clear_addr + CW'(1);
      end
    end
  end

  // The column word read for a pixel is written back, shifted up by one
  // row with the new pixel on top, when that pixel leaves stage 1. When
  // the next pixel reads the same column in that cycle (two frame starts
  // in a row), the read misses the write and the new word is forwarded.
  always_comb begin
    s1_line = s1_fwd ? s1_fwd_data : line_t'(mem_rdata);
    for (int k = 0; k < KERNEL_SIZE - 2; k++) begin
      s1_line_next[k] = s1_line[k + 1];
    end
    s1_line_next[KERNEL_SIZE-2] = s1_px;
    for (int r = 0; r < KERNEL_SIZE - 1; r++) begin
      s1_column[r] = s1_line[r];
    end
    s1_column[KERNEL_SIZE-1] = s1_px;
    for (int r = 0; r < KERNEL_SIZE; r++) begin
      for (int k = 0; k < KERNEL_SIZE - 1; k++) begin
        window_next[r][k] = window[r][k + 1];
      end
      window_next[r][KERNEL_SIZE-1] = s1_column[r];
    end
  end

  assign mem_we    = clearing || s1_leave;
  assign mem_waddr = clearing ? clear_addr : s1_col;
  assign mem_wdata = clearing ? '0 : LW'(s1_line_next);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (accept) begin
      mem_rdata <= mem[cur_col];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
      s2_v <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_v <= accept;
      end
      if (s2_ready) begin
        s2_v <= s1_v;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_col      <= cur_col;
      s1_px       <= req.pixel;
      s1_pos      <= cur_pos;
      s1_emit     <= cur_emit;
      s1_fwd      <= s1_leave && (s1_col == cur_col);
      s1_fwd_data <= s1_line_next;
    end
    if (s1_leave) begin
      s2_pos  <= s1_pos;
      s2_emit <= s1_emit;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window <= '0;
    end else if (s1_leave) begin
      window <= window_next;
    end
  end

  lmc_kernel u_kernel (
    .clk        (clk),
    .rst        (rst),
    .take_valid (s2_v && s2_emit),
    .take_ready (k_ready),
    .win        (window),
    .tag        (s2_pos),
    .rsp_valid  (rsp_valid),
    .rsp_stall  (rsp_stall),
    .rsp        (rsp)
  );

endmodule

// File: rtl/lmc_checker.sv
`timescale 1ns / 1ps

module lmc_props (
  input logic              clk,
  input logic              rst,
  input logic              req_stall,
  input logic              rsp_valid,
  input logic              rsp_stall,
  input lmc_pkg::lmc_rsp_t rsp
);
  import lmc_pkg::*;

  // Reset empties the pipeline and starts the line-store sweep.
  a_reset_state: assert property (@(posedge clk)
    rst |=> !rsp_valid && req_stall)
    else $error("pipeline not empty or requests taken right after reset");

  // The sweep holds req_stall high right after reset, so no request is taken then.
  a_sweep_stalls: assert property (@(posedge clk)
    $fell(rst) |-> req_stall ##1 req_stall ##1 req_stall)
    else $error("request taken during the line-store sweep");

  // A stalled response stays in place.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("stalled response dropped or changed");

endmodule

bind log_mask_convolution lmc_props u_lmc_checker (
  .clk       (clk),
  .rst       (rst),
  .req_stall (req_stall),
  .rsp_valid (rsp_valid),
  .rsp_stall (rsp_stall),
  .rsp       (rsp)
);
